// File: src/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: src/mpwm_pkg.sv
// ----------------------------------------------------------------------------
// mpwm_pkg
// Types and constants of the polar mecanum wheel mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package mpwm_pkg;

    localparam int CORDIC_STEPS = 30;

    localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

    localparam logic signed [32:0] CORDIC_X0 = 33'sh0_4000_0000;

    // atan(2^-i) as a fraction of a full turn, 2^32 per turn
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic               flip;
        logic [14:0]        power;
        logic signed [15:0] turn;
        logic [16:0]        span;   // power + |turn|
        logic               scale;  // span exceeds one
    } side_t;

    typedef struct packed {
        logic signed [31:0] z;
        side_t              side;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] lf;
        logic signed [15:0] rf;
        logic signed [15:0] lb;
        logic signed [15:0] rb;
    } speed_t;

endpackage

`default_nettype wire

// File: src/mecanum_polar_wheel_mixer.sv
// ----------------------------------------------------------------------------
// mecanum_polar_wheel_mixer
// Heading, power and turn command in; four mecanum wheel speeds out.
// ----------------------------------------------------------------------------
// Usage
//   Command side is a queue write port: a command transfers on a clock edge
//   with push high and full low. Results come out of a queue read port: the
//   oldest set of wheel speeds sits on the speed ports while empty is low
//   and transfers on an edge with pop high.
//   One command gives one result. Throughput is one command per cycle while
//   the reader keeps up; the figure is set by the fully pipelined CORDIC
//   (one stage per iteration) and the restoring dividers (one quotient bit
//   per stage).
//   Reset empties both queues and clears every pipeline valid bit.
//   When the reader stalls, the execution pipeline freezes as soon as its
//   last stage holds a result the output queue cannot take; the command
//   queue then fills and full rises. Nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mecanum_polar_wheel_mixer #(
    parameter int FRAC_BITS  = 14,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [15:0] heading,
    input  wire logic [14:0]        drive_power,
    input  wire logic signed [15:0] turn_rate,
    input  wire logic               pop,
    output logic                    empty,
    output logic signed [15:0]      left_front_speed,
    output logic signed [15:0]      right_front_speed,
    output logic signed [15:0]      left_back_speed,
    output logic signed [15:0]      right_back_speed
);

    localparam int CMD_W = $bits(mpwm_pkg::cmd_t);
    localparam int SPD_W = $bits(mpwm_pkg::speed_t);
    localparam logic signed [32:0] ONE_S = 33'sd1 <<< FRAC_BITS;

    mpwm_pkg::cmd_t   front_cmd;
    logic [CMD_W-1:0] mid_rdata;
    logic             mid_full;
    logic             mid_empty;
    logic             mid_pop;
    logic             ce;
    logic             b_valid;
    mpwm_pkg::speed_t b_speed;
    logic             res_full;
    logic             res_push;
    logic [SPD_W-1:0] res_rdata;
    mpwm_pkg::speed_t res_speed;

    mpwm_front #(
        .FRAC_BITS  (FRAC_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .heading     (heading),
        .drive_power (drive_power),
        .turn_rate   (turn_rate),
        .cmd         (front_cmd)
    );

    mpwm_fifo #(
        .WIDTH (CMD_W),
        .AW    (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    // advance the pipeline unless the last stage is blocked
    assign ce       = !b_valid || !res_full;
    assign mid_pop  = ce && !mid_empty;
    assign res_push = b_valid && !res_full;
    assign full     = mid_full;

    mpwm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (!mid_empty),
        .in_cmd    (mid_rdata),
        .out_valid (b_valid),
        .out_speed (b_speed)
    );

    mpwm_fifo #(
        .WIDTH (SPD_W),
        .AW    (1)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (b_speed),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_speed         = res_rdata;
    assign left_front_speed  = res_speed.lf;
    assign right_front_speed = res_speed.rf;
    assign left_back_speed   = res_speed.lb;
    assign right_back_speed  = res_speed.rb;

    `ASSERT_NEXT(a_stall_hold, clk, rst_n, b_valid && res_full, $stable(b_speed), "blocked result changed")
    `ASSERT_IMPLIES(a_lf_range, clk, rst_n, !empty, (33'(left_front_speed) <= ONE_S) && (33'(left_front_speed) >= -ONE_S), "left front speed beyond one")
    `ASSERT_IMPLIES(a_rb_range, clk, rst_n, !empty, (33'(right_back_speed) <= ONE_S) && (33'(right_back_speed) >= -ONE_S), "right back speed beyond one")

endmodule

`default_nettype wire

// File: src/mpwm_fifo.sv
// ----------------------------------------------------------------------------
// mpwm_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mpwm_fifo #(
    parameter int WIDTH = 8,
    parameter int AW    = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int DEPTH = 1 << AW;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW:0]      wp_reg;
    logic [AW:0]      rp_reg;
    logic [AW:0]      wp_next;
    logic [AW:0]      rp_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (wp_reg == rp_reg);
    assign full    = (wp_reg[AW] != rp_reg[AW]) && (wp_reg[AW-1:0] == rp_reg[AW-1:0]);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign wp_next = do_push ? wp_reg + 1'b1 : wp_reg;
    assign rp_next = do_pop ? rp_reg + 1'b1 : rp_reg;
    assign rdata   = mem_reg[rp_reg[AW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg[AW-1:0]] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: src/mpwm_front.sv
// ----------------------------------------------------------------------------
// mpwm_front
// Command classification: phase rotate and fold, turn magnitude, scale flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mpwm_front #(
    parameter int FRAC_BITS  = 14,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic signed [15:0] heading,
    input  wire logic [14:0]        drive_power,
    input  wire logic signed [15:0] turn_rate,
    output mpwm_pkg::cmd_t          cmd
);

    localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    localparam logic [31:0] ONE        = 32'd1 << FRAC_BITS;

    logic [31:0]        phase_raw;
    logic [31:0]        phase_rot;
    logic [31:0]        phase_probe;
    logic [31:0]        phase_fold;
    logic               flip;
    logic signed [16:0] turn_ext;
    logic [16:0]        turn_mag;
    logic [16:0]        span;

    always_comb
    begin
        phase_raw   = {heading, 16'h0000} & PHASE_MASK;
        phase_rot   = phase_raw - mpwm_pkg::EIGHTH_TURN;
        phase_probe = phase_rot + mpwm_pkg::QUARTER_TURN;
        // fold into the right half plane; the back end negates x and y
        flip        = phase_probe[31];
        phase_fold  = flip ? phase_rot + mpwm_pkg::HALF_TURN : phase_rot;

        turn_ext = 17'(turn_rate);
        turn_mag = turn_ext[16] ? 17'(-turn_ext) : 17'(turn_ext);
        span     = {2'b00, drive_power} + turn_mag;

        cmd.z          = $signed(phase_fold);
        cmd.side.flip  = flip;
        cmd.side.power = drive_power;
        cmd.side.turn  = turn_rate;
        cmd.side.span  = span;
        cmd.side.scale = ({15'd0, span} > ONE);
    end

endmodule

`default_nettype wire

// File: src/mpwm_div.sv
// ----------------------------------------------------------------------------
// mpwm_div
// Pipelined restoring divider, one quotient bit per stage, with sidecar.
// ----------------------------------------------------------------------------
`default_nettype none

module mpwm_div #(
    parameter int NW = 47,
    parameter int DW = 32,
    parameter int QW = 15,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          ce,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [DW-1:0] in_den,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [QW-1:0]      out_quo,
    output logic [SW-1:0]      out_side
);

    // The numerator must stay below den * 2^QW.
    logic [NW-1:0] r_reg [0:QW-1];
    logic [DW-1:0] d_reg [0:QW-1];
    logic [QW-1:0] q_reg [0:QW];
    logic [SW-1:0] s_reg [0:QW];
    logic          v_reg [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (ce)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            r_reg[0] <= in_num;
            d_reg[0] <= in_den;
            q_reg[0] <= '0;
            s_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [NW:0] trial;

        assign trial = {1'b0, r_reg[i]} - {1'b0, NW'(d_reg[i]) << (QW - 1 - i)};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (ce)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                q_reg[i+1] <= {q_reg[i][QW-2:0], ~trial[NW]};
                s_reg[i+1] <= s_reg[i];
            end
        end

        if (i < QW - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    r_reg[i+1] <= trial[NW] ? r_reg[i] : trial[NW-1:0];
                    d_reg[i+1] <= d_reg[i];
                end
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign out_quo   = q_reg[QW];
    assign out_side  = s_reg[QW];

endmodule

`default_nettype wire

// File: src/mpwm_back.sv
// ----------------------------------------------------------------------------
// mpwm_back
// Execution pipeline: CORDIC, unit normalize, power product, turn mix, scale.
// ----------------------------------------------------------------------------
`default_nettype none

module mpwm_back #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           ce,
    input  wire logic           in_valid,
    input  wire mpwm_pkg::cmd_t in_cmd,
    output logic                out_valid,
    output mpwm_pkg::speed_t    out_speed
);

    localparam int STEPS = mpwm_pkg::CORDIC_STEPS;
    localparam int QW    = FRAC_BITS + 1;
    localparam int NW1   = FRAC_BITS + 33;
    localparam int NW2   = FRAC_BITS + 18;
    localparam int PW    = FRAC_BITS + 16;
    localparam logic [QW-1:0] ONE_Q  = QW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic            sx;
        logic            sy;
        logic            xbig;
        logic            zero;
        mpwm_pkg::side_t side;
    } d1side_t;

    typedef struct packed {
        logic              sgn;
        logic              scale;
        logic [3:0][17:0]  v;
    } d2side_t;

    function automatic logic [15:0] sat16(input logic signed [32:0] val);
        logic [15:0] res;
        if (val > 33'sd32767)
            res = 16'h7FFF;
        else if (val < -33'sd32768)
            res = 16'h8000;
        else
            res = val[15:0];
        return res;
    endfunction

    // ---------------- CORDIC ----------------
    logic signed [32:0] cx_reg [0:STEPS];
    logic signed [32:0] cy_reg [0:STEPS];
    logic signed [33:0] cz_reg [0:STEPS-1];
    mpwm_pkg::side_t    cs_reg [0:STEPS];
    logic               cv_reg [0:STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= 1'b0;
        end
        else if (ce)
        begin
            cv_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            cx_reg[0] <= mpwm_pkg::CORDIC_X0;
            cy_reg[0] <= '0;
            cz_reg[0] <= 34'(in_cmd.z);
            cs_reg[0] <= in_cmd.side;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cordic
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [33:0] da;

        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;
        assign da = $signed({2'b00, mpwm_pkg::ATAN_TURNS[i]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i+1] <= 1'b0;
            end
            else if (ce)
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                cx_reg[i+1] <= cz_reg[i][33] ? cx_reg[i] + dx : cx_reg[i] - dx;
                cy_reg[i+1] <= cz_reg[i][33] ? cy_reg[i] - dy : cy_reg[i] + dy;
                cs_reg[i+1] <= cs_reg[i];
            end
        end

        if (i < STEPS - 1)
        begin : g_angle
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    cz_reg[i+1] <= cz_reg[i][33] ? cz_reg[i] + da : cz_reg[i] - da;
                end
            end
        end
    end

    // ---------------- pick larger magnitude ----------------
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] mx;
    logic        xbig;
    d1side_t     s1_next;
    logic [31:0] m_reg;
    logic [31:0] sm_reg;
    d1side_t     s1_reg;
    logic        s1v_reg;

    always_comb
    begin
        ax   = cx_reg[STEPS][32] ? 32'(-cx_reg[STEPS]) : 32'(cx_reg[STEPS]);
        ay   = cy_reg[STEPS][32] ? 32'(-cy_reg[STEPS]) : 32'(cy_reg[STEPS]);
        xbig = (ax >= ay);
        mx   = xbig ? ax : ay;
        // flip negates both, so only the signs change
        s1_next.sx   = cx_reg[STEPS][32] ^ cs_reg[STEPS].flip;
        s1_next.sy   = cy_reg[STEPS][32] ^ cs_reg[STEPS].flip;
        s1_next.xbig = xbig;
        s1_next.zero = (mx == 32'd0);
        s1_next.side = cs_reg[STEPS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1v_reg <= 1'b0;
        end
        else if (ce)
        begin
            s1v_reg <= cv_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            m_reg  <= (mx == 32'd0) ? 32'd1 : mx;
            sm_reg <= xbig ? ay : ax;
            s1_reg <= s1_next;
        end
    end

    // ---------------- smaller / larger ----------------
    logic          d1_valid;
    logic [QW-1:0] d1_quo;
    logic [$bits(d1side_t)-1:0] d1_side_raw;
    d1side_t       d1_side;

    mpwm_div #(
        .NW (NW1),
        .DW (32),
        .QW (QW),
        .SW ($bits(d1side_t))
    ) u_div_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s1v_reg),
        .in_num    ((NW1'(sm_reg) << FRAC_BITS) + NW1'(m_reg >> 1)),
        .in_den    (m_reg),
        .in_side   (s1_reg),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_side  (d1_side_raw)
    );

    assign d1_side = d1_side_raw;

    // ---------------- power product ----------------
    logic [QW-1:0]   big_mag;
    logic [QW-1:0]   cmag;
    logic [QW-1:0]   smag;
    logic [PW-1:0]   pa_reg;
    logic [PW-1:0]   pb_reg;
    logic            msx_reg;
    logic            msy_reg;
    mpwm_pkg::side_t ms_reg;
    logic            mv_reg;

    assign big_mag = d1_side.zero ? '0 : ONE_Q;
    assign cmag    = d1_side.xbig ? big_mag : d1_quo;
    assign smag    = d1_side.xbig ? d1_quo : big_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
        end
        else if (ce)
        begin
            mv_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pa_reg  <= PW'(d1_side.side.power) * PW'(cmag);
            pb_reg  <= PW'(d1_side.side.power) * PW'(smag);
            msx_reg <= d1_side.sx;
            msy_reg <= d1_side.sy;
            ms_reg  <= d1_side.side;
        end
    end

    // ---------------- round and sign ----------------
    logic [15:0]        a_mag;
    logic [15:0]        b_mag;
    logic signed [16:0] a_reg;
    logic signed [16:0] b_reg;
    mpwm_pkg::side_t    r1s_reg;
    logic               r1v_reg;

    assign a_mag = 16'((pa_reg + HALF_P) >> FRAC_BITS);
    assign b_mag = 16'((pb_reg + HALF_P) >> FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1v_reg <= 1'b0;
        end
        else if (ce)
        begin
            r1v_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_reg   <= msx_reg ? -$signed({1'b0, a_mag}) : $signed({1'b0, a_mag});
            b_reg   <= msy_reg ? -$signed({1'b0, b_mag}) : $signed({1'b0, b_mag});
            r1s_reg <= ms_reg;
        end
    end

    // ---------------- turn mix ----------------
    logic signed [17:0] v_reg [4];
    logic [16:0]        r2span_reg;
    logic               r2scale_reg;
    logic               r2v_reg;
    logic signed [17:0] t_ext;

    assign t_ext = 18'(r1s_reg.turn);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r2v_reg <= 1'b0;
        end
        else if (ce)
        begin
            r2v_reg <= r1v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            v_reg[0]    <= 18'(a_reg) + t_ext;
            v_reg[1]    <= 18'(b_reg) - t_ext;
            v_reg[2]    <= 18'(b_reg) + t_ext;
            v_reg[3]    <= 18'(a_reg) - t_ext;
            r2span_reg  <= r1s_reg.span;
            r2scale_reg <= r1s_reg.scale;
        end
    end

    // ---------------- magnitude for scaling ----------------
    logic [16:0]        vm_reg [4];
    logic               vs_reg [4];
    logic signed [17:0] vk_reg [4];
    logic [16:0]        span_reg;
    logic               scale_reg;
    logic               r3v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r3v_reg <= 1'b0;
        end
        else if (ce)
        begin
            r3v_reg <= r2v_reg;
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_mag
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                vm_reg[k] <= v_reg[k][17] ? 17'(-v_reg[k]) : 17'(v_reg[k]);
                vs_reg[k] <= v_reg[k][17];
                vk_reg[k] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            span_reg  <= r2span_reg;
            scale_reg <= r2scale_reg;
        end
    end

    // ---------------- scale divide, four lanes ----------------
    logic [QW-1:0] q2   [4];
    logic          v2   [4];
    logic          sg2  [4];
    d2side_t       d2_in;
    d2side_t       d2_out;
    logic [$bits(d2side_t)-1:0] d2_out_raw;

    always_comb
    begin
        d2_in.sgn   = vs_reg[0];
        d2_in.scale = scale_reg;
        for (int k = 0; k < 4; k++)
        begin
            d2_in.v[k] = vk_reg[k];
        end
    end

    assign d2_out = d2_out_raw;
    assign sg2[0] = d2_out.sgn;

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        if (k == 0)
        begin : g_lead
            mpwm_div #(
                .NW (NW2),
                .DW (17),
                .QW (QW),
                .SW ($bits(d2side_t))
            ) u_div_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ce        (ce),
                .in_valid  (r3v_reg),
                .in_num    ((NW2'(vm_reg[k]) << FRAC_BITS) + NW2'(span_reg >> 1)),
                .in_den    (span_reg),
                .in_side   (d2_in),
                .out_valid (v2[k]),
                .out_quo   (q2[k]),
                .out_side  (d2_out_raw)
            );
        end
        else
        begin : g_follow
            mpwm_div #(
                .NW (NW2),
                .DW (17),
                .QW (QW),
                .SW (1)
            ) u_div_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ce        (ce),
                .in_valid  (r3v_reg),
                .in_num    ((NW2'(vm_reg[k]) << FRAC_BITS) + NW2'(span_reg >> 1)),
                .in_den    (span_reg),
                .in_side   (vs_reg[k]),
                .out_valid (v2[k]),
                .out_quo   (q2[k]),
                .out_side  (sg2[k])
            );
        end
    end

    // ---------------- select, saturate ----------------
    logic signed [32:0] fin [4];
    logic               fv_reg;
    mpwm_pkg::speed_t   speed_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (d2_out.scale)
                fin[k] = sg2[k] ? -$signed(33'(q2[k])) : $signed(33'(q2[k]));
            else
                fin[k] = 33'($signed(d2_out.v[k]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (ce)
        begin
            fv_reg <= v2[0] & v2[1] & v2[2] & v2[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            speed_reg.lf <= sat16(fin[0]);
            speed_reg.rf <= sat16(fin[1]);
            speed_reg.lb <= sat16(fin[2]);
            speed_reg.rb <= sat16(fin[3]);
        end
    end

    assign out_valid = fv_reg;
    assign out_speed = speed_reg;

endmodule

`default_nettype wire

// File: tb/mecanum_polar_wheel_mixer_tb.sv
// ----------------------------------------------------------------------------
// mecanum_polar_wheel_mixer_tb
// Self-checking bench for the polar mecanum wheel mixer. A directed table
// and a random phase drive commands through the queue write port with random
// gaps; results are popped with random stalls and compared field by field
// against a CORDIC-based predictor of the four wheel speeds.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_polar_wheel_mixer_tb;

    localparam int  FRAC_BITS   = 14;
    localparam int  ANGLE_BITS  = 16;
    localparam int  ONE         = 1 << FRAC_BITS;
    localparam int  RANDOM_CMDS = 630;
    localparam int  SETTLE      = 2 * FRAC_BITS + 60;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [15:0] heading;
        logic [14:0]        power;
        logic signed [15:0] turn;
        bit                 typed;
        mpwm_pkg::speed_t   speeds;
    } cmd_row_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic signed [15:0] heading;
    logic [14:0]        drive_power;
    logic signed [15:0] turn_rate;
    logic               pop;
    logic               empty;
    logic signed [15:0] left_front_speed;
    logic signed [15:0] right_front_speed;
    logic signed [15:0] left_back_speed;
    logic signed [15:0] right_back_speed;

    mpwm_pkg::speed_t pending_speeds[$];
    int     errors;
    longint cycles;
    bit     burst;

    mecanum_polar_wheel_mixer #(
        .FRAC_BITS  (FRAC_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .heading           (heading),
        .drive_power       (drive_power),
        .turn_rate         (turn_rate),
        .pop               (pop),
        .empty             (empty),
        .left_front_speed  (left_front_speed),
        .right_front_speed (right_front_speed),
        .left_back_speed   (left_back_speed),
        .right_back_speed  (right_back_speed)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // round(num / den), halves away from zero, den > 0
    function automatic longint div_round(longint num, longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic mpwm_pkg::speed_t wheel_speeds(logic signed [15:0] hd,
                                                      logic [14:0] pw,
                                                      logic signed [15:0] tr);
        logic [31:0]      ph;
        bit               flip;
        longint           z, x, y, dx, dy, m, cn, sn, a, b, span, p, t;
        longint           v[4];
        mpwm_pkg::speed_t s;
        ph = {hd, 16'h0000};
        ph &= 32'hFFFF_FFFF << (32 - ANGLE_BITS);
        ph -= mpwm_pkg::EIGHTH_TURN;
        flip = 1'b0;
        // fold into [-pi/2, pi/2) with a half-turn flip
        if (((ph + mpwm_pkg::QUARTER_TURN) & mpwm_pkg::HALF_TURN) != 0)
        begin
            ph += mpwm_pkg::HALF_TURN;
            flip = 1'b1;
        end
        z = longint'($signed(ph));
        x = longint'(1) << 30;
        y = 0;
        for (int i = 0; i < mpwm_pkg::CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(mpwm_pkg::ATAN_TURNS[i]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(mpwm_pkg::ATAN_TURNS[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        m = (x < 0) ? -x : x;
        if (((y < 0) ? -y : y) > m)
            m = (y < 0) ? -y : y;
        if (m == 0)
            m = 1;
        cn = div_round(x * ONE, m);
        sn = div_round(y * ONE, m);
        p = longint'(pw);
        t = longint'(tr);
        a = div_round(p * cn, ONE);
        b = div_round(p * sn, ONE);
        v[0] = a + t;
        v[1] = b - t;
        v[2] = b + t;
        v[3] = a - t;
        span = p + ((t < 0) ? -t : t);
        if (span > ONE)
            for (int i = 0; i < 4; i++)
                v[i] = div_round(v[i] * ONE, span);
        s.lf = clip16(v[0]);
        s.rf = clip16(v[1]);
        s.lb = clip16(v[2]);
        s.rb = clip16(v[3]);
        return s;
    endfunction

    task automatic send_command(logic signed [15:0] hd, logic [14:0] pw,
                                logic signed [15:0] tr, bit typed,
                                mpwm_pkg::speed_t typed_speeds);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        heading     <= hd;
        drive_power <= pw;
        turn_rate   <= tr;
        @(posedge clk);
        while (full !== 1'b0)
            @(posedge clk);
        if (typed)
        begin
            if (typed_speeds !== wheel_speeds(hd, pw, tr))
                $error("table row disagrees with predictor: h=%0d p=%0d t=%0d", hd, pw, tr);
            pending_speeds.push_back(typed_speeds);
        end
        else
            pending_speeds.push_back(wheel_speeds(hd, pw, tr));
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && pop === 1'b1 && empty === 1'b0)
        begin
            if (pending_speeds.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                mpwm_pkg::speed_t want;
                want = pending_speeds.pop_front();
                if (left_front_speed !== want.lf)
                begin
                    $error("left_front_speed: expected %0d, got %0d", want.lf, left_front_speed);
                    errors++;
                end
                if (right_front_speed !== want.rf)
                begin
                    $error("right_front_speed: expected %0d, got %0d", want.rf,
                           right_front_speed);
                    errors++;
                end
                if (left_back_speed !== want.lb)
                begin
                    $error("left_back_speed: expected %0d, got %0d", want.lb, left_back_speed);
                    errors++;
                end
                if (right_back_speed !== want.rb)
                begin
                    $error("right_back_speed: expected %0d, got %0d", want.rb, right_back_speed);
                    errors++;
                end
            end
        end
    end

    // reader with random stalls, some stretches without any
    initial
    begin
        int stall;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = burst ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty !== 1'b0)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("mecanum_polar_wheel_mixer regression: fail");
            $finish;
        end
    end

    initial
    begin
        cmd_row_t rows[$];
        mpwm_pkg::speed_t   none;
        logic signed [15:0] hd;
        logic [14:0]        pw;
        logic signed [15:0] tr;
        int                 kind;
        none        = '0;
        errors      = 0;
        burst       = 1'b0;
        rst_n       <= 1'b0;
        push        <= 1'b0;
        heading     <= '0;
        drive_power <= '0;
        turn_rate   <= '0;

        // no power, no turn: all wheels stop
        rows.push_back('{16'sd0, 15'd0, 16'sd0, 1'b1, '0});
        // pure full turn
        rows.push_back('{16'sd0, 15'd0, 16'sd16384, 1'b1,
                         mpwm_pkg::speed_t'{16'sd16384, -16'sd16384, 16'sd16384,
                                            -16'sd16384}});
        rows.push_back('{16'sd0, 15'd0, -16'sd16384, 1'b1,
                         mpwm_pkg::speed_t'{-16'sd16384, 16'sd16384, -16'sd16384,
                                            16'sd16384}});
        rows.push_back('{16'sd12345, 15'd0, 16'sd0, 1'b1, '0});
        rows.push_back('{16'sd0, 15'd16384, 16'sd0, 1'b0, none});
        rows.push_back('{16'sd8192, 15'd16384, 16'sd0, 1'b0, none});
        rows.push_back('{16'sd16384, 15'd16384, 16'sd0, 1'b0, none});
        rows.push_back('{-16'sd16384, 15'd16384, 16'sd0, 1'b0, none});
        rows.push_back('{-16'sd32768, 15'd16384, 16'sd0, 1'b0, none});
        rows.push_back('{16'sd32767, 15'd16384, 16'sd0, 1'b0, none});
        rows.push_back('{-16'sd24576, 15'd8192, 16'sd4096, 1'b0, none});
        rows.push_back('{16'sd24576, 15'd8192, -16'sd4096, 1'b0, none});
        // power beyond one
        rows.push_back('{16'sd1000, 15'd32767, 16'sd0, 1'b0, none});
        rows.push_back('{-16'sd1, 15'd32767, 16'sd16384, 1'b0, none});
        // turn beyond one, both extremes
        rows.push_back('{16'sd5000, 15'd0, 16'sd32767, 1'b0, none});
        rows.push_back('{16'sd5000, 15'd0, -16'sd32768, 1'b0, none});
        rows.push_back('{-16'sd32768, 15'd32767, -16'sd32768, 1'b0, none});
        rows.push_back('{16'sd32767, 15'd32767, 16'sd32767, 1'b0, none});
        rows.push_back('{16'sd8192, 15'd12000, 16'sd12000, 1'b0, none});
        rows.push_back('{16'sd1, 15'd1, -16'sd1, 1'b0, none});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_command(rows[i].heading, rows[i].power, rows[i].turn,
                         rows[i].typed, rows[i].speeds);

        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 60 == 0)
                burst = ($urandom_range(0, 3) == 0);
            // hold off until the pipeline has drained
            if (n == RANDOM_CMDS / 2)
            begin
                push <= 1'b0;
                @(posedge clk);
                while (pending_speeds.size() != 0)
                    @(posedge clk);
            end
            hd = 16'($urandom);
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                pw = 15'($urandom_range(0, ONE));
                tr = 16'($signed($urandom_range(0, 2 * ONE)) - ONE);
            end
            else
            begin
                pw = 15'($urandom);
                tr = 16'($urandom);
            end
            send_command(hd, pw, tr, 1'b0, none);
        end

        push <= 1'b0;
        @(posedge clk);
        while (pending_speeds.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0)
            $display("mecanum_polar_wheel_mixer regression: pass");
        else
            $display("mecanum_polar_wheel_mixer regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
